>>> sv/modexp_pkg.sv
// Shared types for the modular exponentiation block.
// Controller states and the command and status groups between controller and datapath.
// No dependencies.
package modexp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_RES,
      ST_RED_RES,
      ST_WB_RES,
      ST_MUL_SQ,
      ST_RED_SQ,
      ST_WB_SQ,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture a new operand beat
      logic mul;         // form product, clear reduction
      logic mul_square;  // 1: power*power, 0: result*power
      logic red_step;    // one remainder bit
      logic res_write;   // result <= remainder
      logic pw_write;    // power <= remainder
      logic exp_shift;   // exponent >>= 1
      logic out_write;   // load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic exp_bit0;
      logic red_last;    // final reduction step this cycle
      logic out_free;    // output register can take a beat
   } status_type;

endpackage

>>> sv/modexp_ctrl.sv
// Controller state machine for the modular exponentiation block.
// Sequences load, multiply, bit-serial reduction and write-back. Uses modexp_pkg.
module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.mod_zero || status.exp_zero) begin
               state_in = ST_FINISH;
            end else if (status.exp_bit0) begin
               state_in = ST_MUL_RES;
            end else begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_RES: state_in = ST_RED_RES;
         ST_RED_RES: begin
            if (status.red_last) begin
               state_in = ST_WB_RES;
            end
         end
         ST_WB_RES:  state_in = ST_MUL_SQ;
         ST_MUL_SQ:  state_in = ST_RED_SQ;
         ST_RED_SQ: begin
            if (status.red_last) begin
               state_in = ST_WB_SQ;
            end
         end
         ST_WB_SQ:   state_in = ST_CHECK;
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_MUL_RES: cmd.mul = 1'b1;
         ST_MUL_SQ: begin
            cmd.mul        = 1'b1;
            cmd.mul_square = 1'b1;
         end
         ST_RED_RES, ST_RED_SQ: cmd.red_step = 1'b1;
         ST_WB_RES: cmd.res_write = 1'b1;
         ST_WB_SQ: begin
            cmd.pw_write  = 1'b1;
            cmd.exp_shift = 1'b1;
         end
         ST_FINISH: cmd.out_write = status.out_free;
         default: ;
      endcase
   end

endmodule

>>> sv/modexp_dpath.sv
// Datapath for the modular exponentiation block: operand registers, one
// WIDTH x WIDTH multiplier, a restoring bit-serial remainder unit and the output register.
// Uses modexp_pkg.
module modexp_dpath
   import modexp_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [WIDTH-1:0] base_value,
   input  logic [WIDTH-1:0] exponent,
   input  logic [WIDTH-1:0] modulus,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [WIDTH-1:0] result_value,
   output logic             error_flag
);

   localparam int PW = 2 * WIDTH;
   localparam int CW = $clog2(PW);

   logic [WIDTH-1:0] res_ff;
   logic [WIDTH-1:0] pw_ff;
   logic [WIDTH-1:0] exp_ff;
   logic [WIDTH-1:0] mod_ff;
   logic [PW-1:0]    prod_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_result_ff;
   logic             out_error_ff;

   logic [WIDTH-1:0] mul_a;
   logic [PW-1:0]    prod_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH+1:0] diff;
   logic [WIDTH-1:0] rem_in;

   assign mul_a   = cmd.mul_square ? pw_ff : res_ff;
   assign prod_in = PW'(mul_a) * PW'(pw_ff);

   // shift next product bit into the partial remainder, subtract if it fits
   assign trial  = {rem_ff, prod_ff[PW-1]};
   assign diff   = {1'b0, trial} - {2'b00, mod_ff};
   assign rem_in = diff[WIDTH+1] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= WIDTH'(1);
         pw_ff  <= base_value;
         exp_ff <= exponent;
         mod_ff <= modulus;
      end else begin
         if (cmd.res_write) begin
            res_ff <= rem_ff;
         end
         if (cmd.pw_write) begin
            pw_ff <= rem_ff;
         end
         if (cmd.exp_shift) begin
            exp_ff <= exp_ff >> 1;
         end
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.red_step) begin
         prod_ff <= prod_ff << 1;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + CW'(1);
      end
      if (cmd.out_write) begin
         out_result_ff <= (mod_ff == '0) ? '0 : res_ff;
         out_error_ff  <= (mod_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.mod_zero = (mod_ff == '0);
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_bit0 = exp_ff[0];
   assign status.red_last = (cnt_ff == CW'(PW - 1));
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid   = out_valid_ff;
   assign result_value = out_result_ff;
   assign error_flag   = out_error_ff;

endmodule

>>> sv/modular_exponentiation_top.sv
// Top level of the modular exponentiation block.
// Joins modexp_ctrl and modexp_dpath and packs the stream beats. Uses modexp_pkg.
//
// Computes base_value ** exponent mod modulus by right-to-left square and
// multiply, one operand beat at a time. Each exponent bit takes a check
// state plus, per modular product, a multiply state, bit-serial restoring
// reduction over all 2*WIDTH product bits and a write-back state; a set bit
// takes two products, a clear bit one. Both products share the single
// reduction unit. The exponent scan stops at the highest set bit; an
// exponent of zero returns 1 unreduced (also for a modulus of one). A modulus
// of zero returns result 0 with error_flag set. The result sits in an output
// register, so the next beat is taken while the previous answer still waits
// for rsp_tready. No item is accepted while one is being worked on.
module modular_exponentiation_top
   import modexp_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // base_value, exponent, modulus (WIDTH bits each), zero pad to bytes
   input  logic [((3*WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_value (WIDTH bits), zero pad to bytes
   output logic [((WIDTH+7)/8)*8-1:0]           rsp_tdata,
   // error_flag
   output logic                                 rsp_tuser
);

   localparam int RSP_W = ((WIDTH + 7) / 8) * 8;

   cmd_type          cmd;
   status_type       status;
   logic [WIDTH-1:0] result_value;

   modexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   modexp_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .base_value   (req_tdata[WIDTH-1:0]),
      .exponent     (req_tdata[2*WIDTH-1:WIDTH]),
      .modulus      (req_tdata[3*WIDTH-1:2*WIDTH]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .result_value (result_value),
      .error_flag   (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(result_value);

endmodule
